FILE: hw/rtl/rgbhsl_pkg.sv
// shared types, constants and the divider step function for the rgb to hsl converter
`default_nettype none

package rgbhsl_pkg;

  localparam int CH_W           = 8;
  localparam int Q_W            = 16;
  localparam int REM_W          = 11;  // divisors reach 6 * 255 = 1530
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [Q_W-1:0] hue;
    logic [Q_W-1:0] saturation;
    logic [Q_W-1:0] lightness;
  } hsl_t;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  // operands handed from the front end to the divider pipe
  typedef struct packed {
    logic [REM_W-1:0] sat_rem;
    logic [Q_W-1:0]   sat_low;
    logic [REM_W-1:0] sat_den;
    logic [REM_W-1:0] hue_rem;
    logic [REM_W-1:0] hue_den;
    logic [Q_W-1:0]   lightness;
    logic             achrom;
  } div_op_t;

  // one divider pipe stage
  typedef struct packed {
    logic [REM_W-1:0] sat_rem;
    logic [Q_W-1:0]   sat_low;
    logic [REM_W-1:0] sat_den;
    logic [Q_W-1:0]   sat_q;
    logic [REM_W-1:0] hue_rem;
    logic [REM_W-1:0] hue_den;
    logic [Q_W-1:0]   hue_q;
    logic [Q_W-1:0]   lightness;
    logic             achrom;
  } div_st_t;

  typedef struct packed {
    logic             qbit;
    logic [REM_W-1:0] rem;
  } step_res_t;

  // one restoring division step, remainder stays below the divisor
  function automatic step_res_t div_step(logic [REM_W-1:0] rem, logic nb,
                                         logic [REM_W-1:0] den);
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    step_res_t      res;
    t    = {rem, nb};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      res.qbit = 1'b1;
      res.rem  = diff[REM_W-1:0];
    end else begin
      res.qbit = 1'b0;
      res.rem  = t[REM_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgbhsl_front.sv
// front end: channel max/min, then operands for the dividers and lightness
`default_nettype none

module rgbhsl_front import rgbhsl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  pixel_t  pix,
  output logic    op_valid,
  input  logic    op_ready,
  output div_op_t op
);

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    max_sel_t        sel;
  } front_s1_t;

  front_s1_t s1;
  front_s1_t s1_next;
  logic      s1_vld;
  logic      s1_ok;
  logic      s2_ok;
  div_op_t   op_next;
  logic      op_vld;

  assign s2_ok    = !op_vld || op_ready;
  assign s1_ok    = !s1_vld || s2_ok;
  assign in_ready = s1_ok;
  assign op_valid = op_vld;

  // max with ties to red then green
  always_comb begin
    s1_next.r = pix.red;
    s1_next.g = pix.green;
    s1_next.b = pix.blue;
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      s1_next.sel = SEL_RED;
      s1_next.mx  = pix.red;
    end else if (pix.green >= pix.blue) begin
      s1_next.sel = SEL_GREEN;
      s1_next.mx  = pix.green;
    end else begin
      s1_next.sel = SEL_BLUE;
      s1_next.mx  = pix.blue;
    end
    if (pix.red <= pix.green && pix.red <= pix.blue) begin
      s1_next.mn = pix.red;
    end else if (pix.green <= pix.blue) begin
      s1_next.mn = pix.green;
    end else begin
      s1_next.mn = pix.blue;
    end
  end

  always_comb begin
    logic [CH_W-1:0]   d;
    logic [CH_W:0]     sum;
    logic [CH_W:0]     den;
    logic [REM_W-1:0]  d6;
    logic [REM_W-1:0]  off_d;
    logic [CH_W-1:0]   pa;
    logic [CH_W-1:0]   pb;
    logic [CH_W+Q_W-1:0] sat_x;
    logic [Q_W:0]      lig_x;
    d     = s1.mx - s1.mn;
    sum   = {1'b0, s1.mx} + {1'b0, s1.mn};
    den   = (sum > 9'd255) ? (9'd510 - sum) : sum;
    d6    = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    // d * 65535 as d * 2^16 - d
    sat_x = {d, {Q_W{1'b0}}} - {{Q_W{1'b0}}, d};
    // sum * 65535 / 510 is exactly sum * 257 / 2
    lig_x = {sum, {CH_W{1'b0}}} + {{CH_W{1'b0}}, sum};
    case (s1.sel)
      SEL_RED: begin
        off_d = (s1.g < s1.b) ? d6 : '0;
        pa    = s1.g;
        pb    = s1.b;
      end
      SEL_GREEN: begin
        off_d = {2'b00, d, 1'b0};
        pa    = s1.b;
        pb    = s1.r;
      end
      SEL_BLUE: begin
        off_d = {1'b0, d, 2'b00};
        pa    = s1.r;
        pb    = s1.g;
      end
      default: begin
        off_d = '0;
        pa    = '0;
        pb    = '0;
      end
    endcase
    op_next.sat_rem   = {{(REM_W-CH_W){1'b0}}, sat_x[CH_W+Q_W-1:Q_W]};
    op_next.sat_low   = sat_x[Q_W-1:0];
    op_next.sat_den   = {{(REM_W-CH_W-1){1'b0}}, den};
    // hue numerator lies in [0, 6d), so modular arithmetic is exact
    op_next.hue_rem   = off_d + {{(REM_W-CH_W){1'b0}}, pa} - {{(REM_W-CH_W){1'b0}}, pb};
    op_next.hue_den   = d6;
    op_next.lightness = lig_x[Q_W:1];
    op_next.achrom    = (d == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      op_vld <= 1'b0;
    end else begin
      if (s1_ok) begin
        s1_vld <= in_valid;
      end
      if (s2_ok) begin
        op_vld <= s1_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ok) begin
      s1 <= s1_next;
    end
    if (s2_ok) begin
      op <= op_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbhsl_div.sv
// pipelined restoring dividers for saturation and hue, two quotient bits per stage
`default_nettype none

module rgbhsl_div import rgbhsl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  output logic    op_ready,
  input  div_op_t op,
  output logic    res_valid,
  input  logic    res_ready,
  output div_st_t res
);

  div_st_t               st      [DIV_STAGES];
  div_st_t               st_in   [DIV_STAGES];
  div_st_t               st_next [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   adv_ok;

  always_comb begin
    st_in[0].sat_rem   = op.sat_rem;
    st_in[0].sat_low   = op.sat_low;
    st_in[0].sat_den   = op.sat_den;
    st_in[0].sat_q     = '0;
    st_in[0].hue_rem   = op.hue_rem;
    st_in[0].hue_den   = op.hue_den;
    st_in[0].hue_q     = '0;
    st_in[0].lightness = op.lightness;
    st_in[0].achrom    = op.achrom;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = st[k-1];
    end
  end

  always_comb begin
    div_st_t   cur;
    step_res_t sr;
    step_res_t hr;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = st_in[k];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        sr          = div_step(cur.sat_rem, cur.sat_low[Q_W-1], cur.sat_den);
        hr          = div_step(cur.hue_rem, 1'b0, cur.hue_den);
        cur.sat_rem = sr.rem;
        cur.sat_low = {cur.sat_low[Q_W-2:0], 1'b0};
        cur.sat_q   = {cur.sat_q[Q_W-2:0], sr.qbit};
        cur.hue_rem = hr.rem;
        cur.hue_q   = {cur.hue_q[Q_W-2:0], hr.qbit};
      end
      st_next[k] = cur;
    end
  end

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv_ok[DIV_STAGES] = res_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      adv_ok[k] = !vld[k] || adv_ok[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv_ok[0]) begin
        vld[0] <= op_valid;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (adv_ok[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (adv_ok[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign op_ready  = adv_ok[0];
  assign res_valid = vld[DIV_STAGES-1];
  assign res       = st[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_to_hsl_converter_unit.sv
// top level of the rgb to hsl converter: front end, divider pipe and output register
`default_nettype none

// Converts one 8-bit rgb pixel per clock, unless the output stalls, into 16-bit
// hue, saturation and lightness. Hue is a fraction of the full circle scaled by
// 65536, saturation and lightness are fractions scaled by 65535, all truncated;
// a gray pixel (max equal to min) gives hue and saturation of zero, and ties for
// the maximum channel go to red, then green. The block is fully pipelined: a
// new pixel can enter every clock, and each one passes two front-end stages,
// eight stages of the radix-4 dividers and one output register on its way
// from the accepting edge to its result beat; the divider depth follows from
// two quotient bits per stage over 16 bits. Every stage holds its own valid
// bit and fills when empty, so a stall on the result side backs up only as far
// as the pipe is full, and pixels keep entering into empty stages meanwhile.
// There is no configuration and no state between pixels.

module rgb_to_hsl_converter_unit import rgbhsl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   hsl_valid,
  input  logic   hsl_stall,
  output hsl_t   hsl
);

  logic    front_ready;
  logic    op_valid;
  logic    op_ready;
  div_op_t op;
  logic    res_valid;
  logic    res_ready;
  div_st_t res;
  logic    out_vld;
  hsl_t    hsl_next;

  assign pixel_stall = !front_ready;

  // max/min, differences, divisors and lightness
  rgbhsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_valid),
    .in_ready (front_ready),
    .pix      (pixel),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // saturation and hue quotients side by side
  rgbhsl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes a new beat whenever it is empty or being drained
  assign res_ready = !out_vld || !hsl_stall;

  // gray pixels force hue and saturation to zero
  always_comb begin
    hsl_next.hue        = res.achrom ? '0 : res.hue_q;
    hsl_next.saturation = res.achrom ? '0 : res.sat_q;
    hsl_next.lightness  = res.lightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_ready) begin
      out_vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      hsl <= hsl_next;
    end
  end

  assign hsl_valid = out_vld;

endmodule

`default_nettype wire

FILE: tb/sv/rgb_to_hsl_converter_unit_test.sv
// self-checking testbench for the rgb to hsl converter unit
`timescale 1ns / 100ps

module rgb_to_hsl_converter_unit_test;
  import rgbhsl_pkg::*;

  localparam int LATENCY       = 11;    // accepting edge to result beat
  localparam int RANDOM_PIXELS = 1926;
  localparam int IDLE_PCT      = 12;
  localparam int QUIET_FROM    = 900;   // no idling on either side in this window
  localparam int QUIET_TO      = 1300;
  localparam int HOLDOFF_AT    = 400;   // results checked before the long output hold-off
  localparam int HOLDOFF_LEN   = 64;
  localparam int DRAIN_AT      = 1500;  // pixels sent before the sender waits for a drain
  localparam int REPORT_MAX    = 10;

  // one expected result together with the pixel that caused it
  typedef struct packed {
    pixel_t px;
    hsl_t   hsl;
  } hsl_expect_t;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel       = '0;
  logic   hsl_valid;
  logic   hsl_stall   = 1'b0;
  hsl_t   hsl;

  pixel_t      pixel_feed_q[$];   // pixels still to be offered
  hsl_expect_t hsl_expect_q[$];   // conversions accepted but not yet returned

  int pixels_sent     = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int gray_pixels     = 0;
  int tied_pixels     = 0;
  int holdoff_left    = 0;
  bit holdoff_done    = 1'b0;
  bit drain_hold      = 1'b0;
  bit drain_done      = 1'b0;

  rgb_to_hsl_converter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsl_valid   (hsl_valid),
    .hsl_stall   (hsl_stall),
    .hsl         (hsl)
  );

  always #5 clk = ~clk;

  // fixed-point conversion of one pixel, exact integer math with truncation
  function automatic hsl_t compute_hsl(pixel_t p);
    int       r, g, b, mx, mn, d, s, num, off, q;
    max_sel_t sel;
    hsl_t     h;
    r   = p.red;
    g   = p.green;
    b   = p.blue;
    // ties for the maximum go to red first, then green
    mx  = r;
    sel = SEL_RED;
    if (g > mx) begin
      mx  = g;
      sel = SEL_GREEN;
    end
    if (b > mx) begin
      mx  = b;
      sel = SEL_BLUE;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    q = (s * 65535) / 510;
    h.lightness = q[15:0];
    h.hue        = '0;
    h.saturation = '0;
    // a gray pixel keeps hue and saturation at zero
    if (d != 0) begin
      if (s > 255) q = (d * 65535) / (510 - s);
      else q = (d * 65535) / s;
      h.saturation = q[15:0];
      case (sel)
        SEL_RED: begin
          num = g - b;
          off = (g < b) ? 6 : 0;  // wraps negative hue back into the circle
        end
        SEL_GREEN: begin
          num = b - r;
          off = 2;
        end
        default: begin
          num = r - g;
          off = 4;
        end
      endcase
      q = ((num + off * d) * 65536) / (6 * d);
      h.hue = q[15:0];
    end
    return h;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = r[7:0];
    p.green = g[7:0];
    p.blue  = b[7:0];
    pixel_feed_q.push_back(p);
    if (r == g && g == b) gray_pixels++;
    else if (r == g || g == b || r == b) tied_pixels++;
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  function automatic bit idle_roll(int progress);
    if (progress >= QUIET_FROM && progress < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // sender: holds a stalled beat, otherwise offers the next pixel or idles
  always @(posedge clk) begin : pixel_driver
    bit go;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        hsl_expect_q.push_back('{px: pixel, hsl: compute_hsl(pixel)});
        pixels_sent++;
        // once in the run, stop offering until everything has come back
        if (pixels_sent == DRAIN_AT && !drain_done) begin
          drain_hold = 1'b1;
          drain_done = 1'b1;
        end
      end
      if (drain_hold && hsl_expect_q.size() == 0) drain_hold = 1'b0;
      if (!(pixel_valid && pixel_stall)) begin
        go = pixel_feed_q.size() != 0 && !drain_hold && !idle_roll(pixels_sent);
        if (go) begin
          pixel_valid <= 1'b1;
          pixel       <= pixel_feed_q.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every accepted result beat against the oldest expectation
  always @(posedge clk) begin : hsl_monitor
    hsl_expect_t want;
    if (rst) begin
      hsl_stall <= 1'b0;
    end else begin
      if (hsl_valid && !hsl_stall) begin
        if (hsl_expect_q.size() == 0) begin
          flag_mismatch($sformatf("result beat %h with nothing expected", hsl));
        end else begin
          want = hsl_expect_q.pop_front();
          if (hsl.hue !== want.hsl.hue)
            flag_mismatch($sformatf("rgb %h hue expected %h got %h",
                                    want.px, want.hsl.hue, hsl.hue));
          if (hsl.saturation !== want.hsl.saturation)
            flag_mismatch($sformatf("rgb %h saturation expected %h got %h",
                                    want.px, want.hsl.saturation, hsl.saturation));
          if (hsl.lightness !== want.hsl.lightness)
            flag_mismatch($sformatf("rgb %h lightness expected %h got %h",
                                    want.px, want.hsl.lightness, hsl.lightness));
        end
        results_checked++;
      end
      // one long hold-off so the pipe fills and backs up into the input
      if (!holdoff_done && results_checked >= HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_LEN;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        hsl_stall <= 1'b1;
      end else begin
        hsl_stall <= idle_roll(results_checked);
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int kind, a, b, c;
    // directed: extremes, pure and mixed primaries, ties, hue wrap, sum edges
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(255, 0, 1);
    add_pixel(255, 1, 0);
    add_pixel(200, 100, 200);
    add_pixel(254, 255, 255);
    add_pixel(100, 200, 200);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 1);
    add_pixel(200, 55, 100);
    add_pixel(200, 56, 100);
    add_pixel(255, 0, 128);
    add_pixel(10, 20, 30);
    add_pixel(30, 20, 10);
    add_pixel(20, 30, 10);
    add_pixel(170, 85, 0);
    add_pixel(127, 128, 129);
    // random: mostly free channels, plus gray, tied and extreme mixes
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      kind = $urandom_range(99);
      a    = $urandom_range(255);
      b    = $urandom_range(255);
      c    = $urandom_range(255);
      if (kind < 60) begin
        add_pixel(a, b, c);
      end else if (kind < 70) begin
        add_pixel(a, a, a);
      end else if (kind < 85) begin
        case ($urandom_range(2))
          0: add_pixel(a, a, b);
          1: add_pixel(a, b, a);
          default: add_pixel(b, a, a);
        endcase
      end else begin
        add_pixel(($urandom_range(2) == 0) ? 0 : ($urandom_range(1) == 0) ? 255 : a,
                  ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) == 0) ? 255 : b,
                  ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) == 0) ? 255 : c);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pixel_feed_q.size() != 0 || pixel_valid) @(posedge clk);
    while (hsl_expect_q.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (2 * LATENCY) @(posedge clk);

    if (hsl_expect_q.size() != 0) $display("%0d results never arrived", hsl_expect_q.size());
    $display("converted %0d pixels (%0d gray, %0d with a tied channel), %0d results checked",
             pixels_sent, gray_pixels, tied_pixels, results_checked);
    $display("long output hold-off and an input drain pause included, %0d mismatches",
             mismatches);
    if (mismatches == 0 && hsl_expect_q.size() == 0) begin
      $display("[rgb_to_hsl_converter_unit] OK");
    end else begin
      $display("[rgb_to_hsl_converter_unit] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("timeout with %0d results still expected", hsl_expect_q.size());
    $display("[rgb_to_hsl_converter_unit] ERROR");
    $finish;
  end

endmodule
